@@ hdl/dmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types and codes of the maximal-munch DFA tokenizer.
// ----------------------------------------------------------------------------
package dmt_pkg;

	localparam logic [2:0] FUNC_LOAD_TRANS  = 3'd0;
	localparam logic [2:0] FUNC_LOAD_ACCEPT = 3'd1;
	localparam logic [2:0] FUNC_LOAD_DELIM  = 3'd2;
	localparam logic [2:0] FUNC_DATA        = 3'd3;
	localparam logic [2:0] FUNC_END         = 3'd4;

	localparam logic [1:0] KIND_MATCH    = 2'd0;
	localparam logic [1:0] KIND_UNCAUGHT = 2'd1;
	localparam logic [1:0] KIND_END      = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic [7:0] NEWLINE = 8'h0A;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  state_index;
		logic [7:0]  byte_value;
		logic [7:0]  target_state;
		logic        next_valid;
		logic [31:0] accept_types;
		logic        delimiter_flag;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  token_kind;
		logic [31:0] first_pos;
		logic [31:0] end_pos;
		logic [31:0] line_number;
		logic [31:0] type_mask;
		logic        last_of_run;
	} out_word_t;

	// Table read requests from the scan engine.
	typedef struct packed {
		logic       tr_re;
		logic [7:0] tr_state;
		logic [7:0] tr_sym;
		logic       acc_re;
		logic [7:0] acc_state;
		logic       dl_re;
		logic [7:0] dl_sym;
	} rd_req_t;

	// Registered table read data.
	typedef struct packed {
		logic        tr_valid;
		logic [7:0]  tr_next;
		logic [31:0] acc;
		logic        dl;
	} rd_data_t;

endpackage

@@ hdl/dmt_ifs.sv @@
// ----------------------------------------------------------------------------
// dmt_in_if / dmt_out_if
// Valid/ready channels that carry input words and result words.
// ----------------------------------------------------------------------------
interface dmt_in_if import dmt_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dmt_out_if import dmt_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/dfa_maximal_munch_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// dfa_maximal_munch_tokenizer_top
// Table-driven maximal-munch DFA tokenizer with a bounded byte ring.
// ----------------------------------------------------------------------------
// Timing: a data byte holds input ready low while the engine writes it to the
// ring and walks it through the registered ring, accept-mask and transition
// reads; each rescanned or skipped ring byte passes through those reads again.
// Load words are written while the engine stays idle; results leave through
// a one-word hold stage and a registered output. Reset: a clearing pass over
// NUM_STATES*256 entries (at most 65536) holds ready low.
module dfa_maximal_munch_tokenizer_top import dmt_pkg::*; #(
	parameter int NUM_STATES = 256,
	parameter int NUM_TYPES  = 32,
	parameter int RING_BYTES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dmt_in_if.sink    tok_in,
	dmt_out_if.source tok_out,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	// Delimiter mode register; write only while the tokenizer is idle (not enforced).
	logic den_q;

	logic      clear_busy;
	logic      eng_idle;
	logic      in_acc;
	rd_req_t   rd_req;
	rd_data_t  rd_data;
	logic      emit_v, emit_ok, flush_v;
	out_word_t emit_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 1'b0;
		end else if (cfg_we) begin
			den_q <= cfg_wdata;
		end
	end

	// Words are taken only while the scan engine rests and the tables are
	// out of their clearing pass.
	assign tok_in.ready = eng_idle && !clear_busy;
	assign in_acc       = tok_in.valid && tok_in.ready;

	dmt_tables #(.NUM_STATES(NUM_STATES), .NUM_TYPES(NUM_TYPES)) u_tables (
		.clk(clk), .arst_n(arst_n), .load_v(in_acc), .load_word(tok_in.payload),
		.rd_req(rd_req), .rd_data(rd_data), .clear_busy(clear_busy)
	);

	dmt_engine #(.RING_BYTES(RING_BYTES)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(in_acc), .item(tok_in.payload),
		.den(den_q), .rd_data(rd_data), .emit_ok(emit_ok), .rd_req(rd_req),
		.idle(eng_idle), .emit_v(emit_v), .emit_word(emit_word), .flush_v(flush_v)
	);

	// The emit stage marks the final result of each run once it is known.
	dmt_emit u_emit (
		.clk(clk), .arst_n(arst_n), .emit_v(emit_v), .emit_word(emit_word),
		.flush_v(flush_v), .emit_ok(emit_ok), .tok_out(tok_out)
	);

endmodule

@@ hdl/dmt_ram.sv @@
// ----------------------------------------------------------------------------
// dmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/dmt_tables.sv @@
// ----------------------------------------------------------------------------
// dmt_tables
// Transition, accept-mask and delimiter memories with their clearing sweep.
// ----------------------------------------------------------------------------
module dmt_tables import dmt_pkg::*; #(
	parameter int NUM_STATES = 256,
	parameter int NUM_TYPES  = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load_v,
	input  in_word_t load_word,
	input  rd_req_t  rd_req,
	output rd_data_t rd_data,
	output logic     clear_busy
);

	localparam int EFF    = (NUM_STATES > 256) ? 256 : NUM_STATES;
	localparam int SW     = $clog2(EFF);
	localparam int TDEPTH = EFF * 256;
	localparam int TAW    = SW + 8;
	localparam int TYW    = (NUM_TYPES >= 32) ? 32 : NUM_TYPES;

	logic           clr_q;
	logic [TAW-1:0] cnt_q;

	logic           tr_we, acc_we, dl_we;
	logic [TAW-1:0] tr_waddr;
	logic [SW:0]    tr_wdata;
	logic [SW-1:0]  acc_waddr;
	logic [TYW-1:0] acc_wdata;
	logic [7:0]     dl_waddr;
	logic           dl_wdata;
	logic           si_ok, ns_ok;
	logic [SW:0]    tr_rdata;
	logic [TYW-1:0] acc_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == TAW'(TDEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clear_busy = clr_q;
	assign si_ok = 32'(load_word.state_index) < 32'(NUM_STATES);
	assign ns_ok = 32'(load_word.target_state) < 32'(NUM_STATES);

	always_comb begin
		tr_we     = 1'b0;
		tr_waddr  = {load_word.state_index[SW-1:0], load_word.byte_value};
		tr_wdata  = {load_word.next_valid, load_word.target_state[SW-1:0]};
		acc_we    = 1'b0;
		acc_waddr = load_word.state_index[SW-1:0];
		acc_wdata = load_word.accept_types[TYW-1:0];
		dl_we     = 1'b0;
		dl_waddr  = load_word.byte_value;
		dl_wdata  = load_word.delimiter_flag;
		if (clr_q) begin
			// The sweep covers every state and byte, so all three stores clear.
			tr_we     = 1'b1;
			tr_waddr  = cnt_q;
			tr_wdata  = '0;
			acc_we    = 1'b1;
			acc_waddr = cnt_q[TAW-1:8];
			acc_wdata = '0;
			dl_we     = 1'b1;
			dl_waddr  = cnt_q[7:0];
			dl_wdata  = 1'b0;
		end else if (load_v) begin
			case (load_word.func)
				FUNC_LOAD_TRANS: begin
					tr_we = si_ok && (!load_word.next_valid || ns_ok);
					if (!load_word.next_valid) begin
						tr_wdata = '0;
					end
				end
				FUNC_LOAD_ACCEPT: acc_we = si_ok;
				FUNC_LOAD_DELIM:  dl_we = 1'b1;
				default: ;
			endcase
		end
	end

	dmt_ram #(.WIDTH(SW + 1), .DEPTH(TDEPTH)) u_trans (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.re(rd_req.tr_re), .raddr({rd_req.tr_state[SW-1:0], rd_req.tr_sym}),
		.rdata(tr_rdata)
	);

	dmt_ram #(.WIDTH(TYW), .DEPTH(EFF)) u_accept (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.re(rd_req.acc_re), .raddr(rd_req.acc_state[SW-1:0]), .rdata(acc_rdata)
	);

	dmt_ram #(.WIDTH(1), .DEPTH(256)) u_delim (
		.clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
		.re(rd_req.dl_re), .raddr(rd_req.dl_sym), .rdata(rd_data.dl)
	);

	assign rd_data.tr_valid = tr_rdata[SW];
	assign rd_data.tr_next  = 8'(tr_rdata[SW-1:0]);
	assign rd_data.acc      = 32'(acc_rdata);

endmodule

@@ hdl/dmt_emit.sv @@
// ----------------------------------------------------------------------------
// dmt_emit
// Holds the newest result until the next one or the end of the run shows
// whether it is the last, then passes it to the output register.
// ----------------------------------------------------------------------------
module dmt_emit import dmt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          emit_v,
	input  out_word_t     emit_word,
	input  logic          flush_v,
	output logic          emit_ok,
	dmt_out_if.source     tok_out
);

	out_word_t pend_q, out_q;
	out_word_t pend_mid, pend_fin;
	logic      pend_v_q, out_v_q;
	logic      out_free;
	logic      emit_go, flush_go;

	assign out_free = !out_v_q || tok_out.ready;
	assign emit_ok  = !pend_v_q || out_free;
	assign emit_go  = emit_v && emit_ok;
	assign flush_go = !emit_go && flush_v && pend_v_q && out_free;

	always_comb begin
		pend_mid             = pend_q;
		pend_mid.last_of_run = 1'b0;
		pend_fin             = pend_q;
		pend_fin.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_v_q  <= pend_v_q || (out_v_q && !tok_out.ready);
				pend_v_q <= 1'b1;
			end else if (flush_go) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (out_v_q && tok_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			if (pend_v_q) begin
				out_q <= pend_mid;
			end
			pend_q <= emit_word;
		end else if (flush_go) begin
			out_q <= pend_fin;
		end
	end

	assign tok_out.valid   = out_v_q;
	assign tok_out.payload = out_q;

endmodule

@@ hdl/dmt_engine.sv @@
// ----------------------------------------------------------------------------
// dmt_engine
// Scan sequencer: byte ring, DFA walk, candidate tracking, rewinds and skips.
// ----------------------------------------------------------------------------
module dmt_engine import dmt_pkg::*; #(
	parameter int RING_BYTES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  item,
	input  logic      den,
	input  rd_data_t  rd_data,
	input  logic      emit_ok,
	output rd_req_t   rd_req,
	output logic      idle,
	output logic      emit_v,
	output out_word_t emit_word,
	output logic      flush_v
);

	localparam int RAW = $clog2(RING_BYTES);
	localparam int RDEPTH = 1 << RAW;

	typedef enum logic [3:0] {
		S_IDLE, S_OVF, S_DRAIN_RD, S_DRAIN_CK, S_WBYTE, S_TOP, S_SB, S_SC,
		S_NL1, S_NL2, S_RES, S_RS_U, S_RS_M, S_RE_U, S_RE_E, S_FIN
	} state_t;

	state_t      st_q;
	logic [31:0] scan_q, recv_q, tstart_q, cend_q, pme_q, line_q, cline_q, pml_q;
	logic [31:0] ctypes_q;
	logic [7:0]  cur_q, byte_q;
	logic        cv_q, skip_q, end_seen_q, end_done_q, eof_q;

	logic           ring_re, ring_we;
	logic [RAW-1:0] ring_raddr;
	logic [7:0]     ring_rd;
	logic           avail, is_nl, hit, cv1, nl_sp, need_rs_u, need_re_u;

	dmt_ram #(.WIDTH(8), .DEPTH(RDEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(recv_q[RAW-1:0]), .wdata(byte_q),
		.re(ring_re), .raddr(ring_raddr), .rdata(ring_rd)
	);

	assign avail     = scan_q != recv_q;
	assign is_nl     = !eof_q && (ring_rd == NEWLINE);
	assign hit       = (rd_data.acc != '0) && (scan_q != tstart_q) &&
	                   (eof_q || !den || rd_data.dl);
	assign cv1       = cv_q || hit;
	assign nl_sp     = is_nl && den && !cv1;
	assign need_rs_u = pme_q != tstart_q;
	assign need_re_u = pme_q != scan_q;
	assign idle      = st_q == S_IDLE;
	assign ring_we   = st_q == S_WBYTE;
	assign ring_raddr = scan_q[RAW-1:0];

	always_comb begin
		rd_req    = '0;
		ring_re   = 1'b0;
		emit_v    = 1'b0;
		emit_word = '0;
		flush_v   = 1'b0;
		unique case (st_q)
			S_TOP: begin
				ring_re          = avail;
				rd_req.acc_re    = 1'b1;
				rd_req.acc_state = cur_q;
			end
			S_SB: begin
				rd_req.tr_re    = 1'b1;
				rd_req.tr_state = skip_q ? 8'd0 : cur_q;
				rd_req.tr_sym   = ring_rd;
				rd_req.dl_re    = 1'b1;
				rd_req.dl_sym   = ring_rd;
			end
			S_SC: begin
				if (!skip_q && nl_sp) begin
					rd_req.tr_re  = 1'b1;
					rd_req.tr_sym = NEWLINE;
				end
			end
			S_NL1: begin
				rd_req.acc_re    = 1'b1;
				rd_req.acc_state = rd_data.tr_next;
			end
			S_DRAIN_RD: ring_re = avail;
			S_OVF: begin
				emit_v    = 1'b1;
				emit_word = '{KIND_OVERFLOW, pme_q, recv_q, pml_q, 32'd0, 1'b0};
			end
			S_RS_U: begin
				emit_v    = need_rs_u;
				emit_word = '{KIND_UNCAUGHT, pme_q, tstart_q, pml_q, 32'd0, 1'b0};
			end
			S_RS_M: begin
				emit_v    = 1'b1;
				emit_word = '{KIND_MATCH, tstart_q, cend_q, cline_q, ctypes_q, 1'b0};
			end
			S_RE_U: begin
				emit_v    = need_re_u;
				emit_word = '{KIND_UNCAUGHT, pme_q, scan_q, pml_q, 32'd0, 1'b0};
			end
			S_RE_E: begin
				emit_v    = 1'b1;
				emit_word = '{KIND_END, scan_q, scan_q, line_q, 32'd0, 1'b0};
			end
			S_FIN: flush_v = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			scan_q     <= '0;
			recv_q     <= '0;
			tstart_q   <= '0;
			cend_q     <= '0;
			pme_q      <= '0;
			line_q     <= '0;
			cline_q    <= '0;
			pml_q      <= '0;
			ctypes_q   <= '0;
			cur_q      <= '0;
			byte_q     <= '0;
			cv_q       <= 1'b0;
			skip_q     <= 1'b0;
			end_seen_q <= 1'b0;
			end_done_q <= 1'b0;
			eof_q      <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (start && !end_done_q) begin
						if (item.func == FUNC_DATA) begin
							byte_q <= item.byte_value;
							if ((recv_q - pme_q) >= 32'(RING_BYTES)) begin
								st_q <= S_OVF;
							end else begin
								st_q <= S_WBYTE;
							end
						end else if (item.func == FUNC_END) begin
							end_seen_q <= 1'b1;
							st_q       <= S_TOP;
						end
					end
				end
				S_OVF: begin
					if (emit_ok) begin
						st_q <= S_DRAIN_RD;
					end
				end
				S_DRAIN_RD: begin
					if (!avail) begin
						pme_q    <= recv_q;
						pml_q    <= line_q;
						skip_q   <= 1'b0;
						tstart_q <= scan_q;
						cur_q    <= '0;
						cv_q     <= 1'b0;
						ctypes_q <= '0;
						st_q     <= S_WBYTE;
					end else begin
						st_q <= S_DRAIN_CK;
					end
				end
				S_DRAIN_CK: begin
					line_q <= line_q + 32'(ring_rd == NEWLINE);
					scan_q <= scan_q + 32'd1;
					st_q   <= S_DRAIN_RD;
				end
				S_WBYTE: begin
					recv_q <= recv_q + 32'd1;
					st_q   <= S_TOP;
				end
				S_TOP: begin
					if (!avail && !end_seen_q) begin
						st_q <= S_FIN;
					end else if (!avail && skip_q) begin
						skip_q   <= 1'b0;
						tstart_q <= scan_q;
						cur_q    <= '0;
						cv_q     <= 1'b0;
						ctypes_q <= '0;
					end else begin
						eof_q <= !avail;
						st_q  <= S_SB;
					end
				end
				S_SB: st_q <= S_SC;
				S_SC: begin
					if (skip_q) begin
						if (rd_data.tr_valid) begin
							skip_q   <= 1'b0;
							tstart_q <= scan_q;
							cur_q    <= '0;
							cv_q     <= 1'b0;
							ctypes_q <= '0;
						end else begin
							line_q <= line_q + 32'(is_nl);
							scan_q <= scan_q + 32'd1;
						end
						st_q <= S_TOP;
					end else begin
						if (hit) begin
							cv_q     <= 1'b1;
							ctypes_q <= rd_data.acc;
							cend_q   <= scan_q;
							cline_q  <= line_q;
						end
						if (!eof_q) begin
							scan_q <= scan_q + 32'd1;
							line_q <= line_q + 32'(is_nl);
						end
						if (nl_sp) begin
							st_q <= S_NL1;
						end else if (!eof_q && rd_data.tr_valid) begin
							cur_q <= rd_data.tr_next;
							st_q  <= S_TOP;
						end else begin
							st_q <= S_RES;
						end
					end
				end
				S_NL1: begin
					// A lone newline becomes a token of its own.
					cv_q     <= 1'b1;
					tstart_q <= scan_q - 32'd1;
					cend_q   <= scan_q;
					cline_q  <= line_q;
					st_q     <= S_NL2;
				end
				S_NL2: begin
					ctypes_q <= rd_data.tr_valid ? rd_data.acc : 32'd0;
					if (rd_data.tr_valid) begin
						cur_q <= rd_data.tr_next;
						st_q  <= S_TOP;
					end else begin
						st_q <= S_RES;
					end
				end
				S_RES: begin
					if (cv_q) begin
						scan_q <= cend_q;
						line_q <= cline_q;
						st_q   <= S_RS_U;
					end else if (eof_q) begin
						st_q <= S_RE_U;
					end else begin
						line_q <= line_q - 32'(is_nl);
						scan_q <= scan_q - 32'd1;
						skip_q <= 1'b1;
						st_q   <= S_TOP;
					end
				end
				S_RS_U: begin
					if (!need_rs_u || emit_ok) begin
						st_q <= S_RS_M;
					end
				end
				S_RS_M: begin
					if (emit_ok) begin
						pme_q    <= cend_q;
						pml_q    <= cline_q;
						tstart_q <= cend_q;
						cur_q    <= '0;
						cv_q     <= 1'b0;
						ctypes_q <= '0;
						st_q     <= S_TOP;
					end
				end
				S_RE_U: begin
					if (!need_re_u || emit_ok) begin
						st_q <= S_RE_E;
					end
				end
				S_RE_E: begin
					if (emit_ok) begin
						pme_q      <= scan_q;
						pml_q      <= line_q;
						tstart_q   <= scan_q;
						cur_q      <= '0;
						cv_q       <= 1'b0;
						ctypes_q   <= '0;
						end_done_q <= 1'b1;
						st_q       <= S_FIN;
					end
				end
				S_FIN: begin
					if (emit_ok) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/dmt_checker.sv @@
// ----------------------------------------------------------------------------
// dmt_checker
// Port-level checks of the tokenizer's result stream.
// ----------------------------------------------------------------------------
module dmt_checker import dmt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [31:0] out_start,
	input logic [31:0] out_end,
	input logic [31:0] out_mask,
	input logic        out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_start) && $stable(out_kind))
		else $error("result word changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_END |-> out_last && out_start == out_end)
		else $error("end token malformed");

	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_MATCH |-> out_start != out_end)
		else $error("empty match");

	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_MATCH |-> out_mask == 32'd0)
		else $error("type mask on a non-match");

endmodule

bind dfa_maximal_munch_tokenizer_top dmt_checker u_dmt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(tok_out.valid),
	.out_ready(tok_out.ready),
	.out_kind(tok_out.payload.token_kind),
	.out_start(tok_out.payload.first_pos),
	.out_end(tok_out.payload.end_pos),
	.out_mask(tok_out.payload.type_mask),
	.out_last(tok_out.payload.last_of_run)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the maximal-munch DFA tokenizer. A small lexer is
// loaded, then byte streams are sent under both delimiter settings, with random
// stalls on both channels in all but the last phase. Every result word is
// checked against an in-bench model of the scanner.
// ----------------------------------------------------------------------------
module tb_top;
	import dmt_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 600;
	localparam int RESULT_CAP = 64;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dmt_in_if  tok_in ();
	dmt_out_if tok_out ();

	dfa_maximal_munch_tokenizer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_in    (tok_in),
		.tok_out   (tok_out),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = ~clk;
	end

	// Scanner model. Its lex_ state mirrors the block's tables and registers.
	bit [8:0]  lex_trans [0:65535];
	bit [31:0] lex_accept [0:255];
	bit        lex_delim [0:255];
	bit [7:0]  lex_ring [0:31];
	bit        lex_delim_en;
	bit [7:0]  lex_state;
	bit [31:0] lex_scan_pos;
	bit [31:0] lex_tok_start;
	bit [31:0] lex_cand_end;
	bit [31:0] lex_prev_end;
	bit [31:0] lex_lines;
	bit [31:0] lex_cand_line;
	bit [31:0] lex_prev_line;
	bit        lex_cand_valid;
	bit [31:0] lex_cand_types;
	bit [31:0] lex_received;
	bit        lex_skipping;
	bit        lex_end_seen;
	bit        lex_end_done;
	int        step_count;

	// Tokens that the block still owes us, oldest first.
	out_word_t token_q[$];
	// Words waiting to be offered on the input channel.
	in_word_t  word_q[$];

	int  error_count;
	int  src_gap;
	int  snk_gap;
	bit  stalls_on;
	int  quiet_cycles;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic push_token(input logic [1:0] kind, input bit [31:0] s,
			input bit [31:0] e, input bit [31:0] line, input bit [31:0] mask);
		out_word_t w;
		if (step_count >= RESULT_CAP) begin
			return;
		end
		w.token_kind  = kind;
		w.first_pos   = s;
		w.end_pos     = e;
		w.line_number = line;
		w.type_mask   = mask;
		w.last_of_run = 1'b0;
		token_q.push_back(w);
		step_count++;
	endtask

	task automatic restart_token();
		lex_tok_start = lex_scan_pos;
		lex_state = 8'd0;
		lex_cand_valid = 1'b0;
		lex_cand_types = '0;
	endtask

	// Walks the buffered bytes until input runs out or the end token goes out.
	task automatic scan_ring();
		bit avail;
		bit eof;
		bit [7:0] c;
		bit [8:0] nx;
		int guard;
		for (guard = 0; guard < 100000; guard++) begin
			avail = lex_scan_pos != lex_received;
			c = 8'd0;
			nx = 9'd0;
			if (!avail && !lex_end_seen) begin
				return;
			end
			if (avail) begin
				c = lex_ring[lex_scan_pos[4:0]];
			end
			eof = !avail;

			if (lex_skipping) begin
				if (eof || lex_trans[{8'd0, c}][8]) begin
					lex_skipping = 1'b0;
					restart_token();
				end else begin
					if (c == NEWLINE) begin
						lex_lines++;
					end
					lex_scan_pos++;
				end
				continue;
			end

			// A state with types counts only when the next byte may end it.
			if (lex_accept[lex_state] != 0 && lex_scan_pos != lex_tok_start &&
					(eof || !lex_delim_en || lex_delim[c])) begin
				lex_cand_valid = 1'b1;
				lex_cand_types = lex_accept[lex_state];
				lex_cand_end = lex_scan_pos;
				lex_cand_line = lex_lines;
			end

			if (!eof) begin
				nx = lex_trans[{lex_state, c}];
				lex_scan_pos++;
				if (c == NEWLINE) begin
					lex_lines++;
					// With delimiters on, a bare newline is a token of its own.
					if (lex_delim_en && !lex_cand_valid) begin
						nx = lex_trans[{8'd0, NEWLINE}];
						lex_cand_valid = 1'b1;
						lex_cand_types = nx[8] ? lex_accept[nx[7:0]] : 32'd0;
						lex_tok_start = lex_scan_pos - 1;
						lex_cand_end = lex_scan_pos;
						lex_cand_line = lex_lines;
					end
				end
			end

			if (!eof && nx[8]) begin
				lex_state = nx[7:0];
				continue;
			end

			if (lex_cand_valid) begin
				// Rewind to the longest match and give out any text before it.
				lex_scan_pos = lex_cand_end;
				lex_lines = lex_cand_line;
				if (lex_prev_end != lex_tok_start) begin
					push_token(KIND_UNCAUGHT, lex_prev_end, lex_tok_start, lex_prev_line,
						32'd0);
				end
				push_token(KIND_MATCH, lex_tok_start, lex_cand_end, lex_cand_line,
					lex_cand_types);
				lex_prev_end = lex_cand_end;
				lex_prev_line = lex_cand_line;
				restart_token();
			end else if (eof) begin
				if (lex_prev_end != lex_scan_pos) begin
					push_token(KIND_UNCAUGHT, lex_prev_end, lex_scan_pos, lex_prev_line,
						32'd0);
				end
				push_token(KIND_END, lex_scan_pos, lex_scan_pos, lex_lines, 32'd0);
				lex_prev_end = lex_scan_pos;
				lex_prev_line = lex_lines;
				restart_token();
				lex_end_done = 1'b1;
				return;
			end else begin
				// No match here: back up one byte and skip to a valid first byte.
				if (c == NEWLINE) begin
					lex_lines--;
				end
				lex_scan_pos--;
				lex_skipping = 1'b1;
			end
		end
	endtask

	task automatic take_byte(input bit [7:0] b);
		if (lex_received - lex_prev_end >= 32) begin
			push_token(KIND_OVERFLOW, lex_prev_end, lex_received, lex_prev_line, 32'd0);
			while (lex_scan_pos != lex_received) begin
				if (lex_ring[lex_scan_pos[4:0]] == NEWLINE) begin
					lex_lines++;
				end
				lex_scan_pos++;
			end
			lex_prev_end = lex_received;
			lex_prev_line = lex_lines;
			lex_skipping = 1'b0;
			restart_token();
		end
		lex_ring[lex_received[4:0]] = b;
		lex_received++;
		scan_ring();
	endtask

	// Applies one accepted input word to the model and queues its tokens.
	task automatic predict_tokens(input in_word_t w);
		out_word_t t;
		step_count = 0;
		case (w.func)
			FUNC_LOAD_TRANS: begin
				if (!w.next_valid) begin
					lex_trans[{w.state_index, w.byte_value}] = 9'd0;
				end else begin
					lex_trans[{w.state_index, w.byte_value}] = {1'b1, w.target_state};
				end
			end
			FUNC_LOAD_ACCEPT: lex_accept[w.state_index] = w.accept_types;
			FUNC_LOAD_DELIM:  lex_delim[w.byte_value] = w.delimiter_flag;
			FUNC_DATA: begin
				if (!lex_end_done) begin
					take_byte(w.byte_value);
				end
			end
			FUNC_END: begin
				if (!lex_end_done) begin
					lex_end_seen = 1'b1;
					scan_ring();
				end
			end
			default: ;
		endcase
		if (step_count > 0) begin
			t = token_q.pop_back();
			t.last_of_run = 1'b1;
			token_q.push_back(t);
		end
	endtask

	function automatic in_word_t noise_word(input logic [2:0] f);
		in_word_t w;
		w.func           = f;
		w.state_index    = 8'($urandom_range(0, 255));
		w.byte_value     = 8'($urandom_range(0, 255));
		w.target_state   = 8'($urandom_range(0, 255));
		w.next_valid     = 1'($urandom_range(0, 1));
		w.accept_types   = $urandom;
		w.delimiter_flag = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic send_trans(input bit [7:0] s, input bit [7:0] b, input bit [7:0] n,
			input bit v);
		in_word_t w;
		w = noise_word(FUNC_LOAD_TRANS);
		w.state_index = s;
		w.byte_value = b;
		w.target_state = n;
		w.next_valid = v;
		word_q.push_back(w);
	endtask

	task automatic send_accept(input bit [7:0] s, input bit [31:0] m);
		in_word_t w;
		w = noise_word(FUNC_LOAD_ACCEPT);
		w.state_index = s;
		w.accept_types = m;
		word_q.push_back(w);
	endtask

	task automatic send_delim(input bit [7:0] b, input bit f);
		in_word_t w;
		w = noise_word(FUNC_LOAD_DELIM);
		w.byte_value = b;
		w.delimiter_flag = f;
		word_q.push_back(w);
	endtask

	task automatic send_byte(input bit [7:0] b);
		in_word_t w;
		w = noise_word(FUNC_DATA);
		w.byte_value = b;
		word_q.push_back(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// Mostly well-formed words of the loaded lexer, with some junk and table loads for states 5 to 255 mixed in.
	task automatic send_random_stream(input int count);
		int k;
		int len;
		string letters;
		letters = "abc";
		k = 0;
		while (k < count) begin
			case ($urandom_range(0, 9))
				0: begin
					send_byte(8'($urandom_range(0, 255)));
					k++;
				end
				1: begin
					send_byte("x");
					k++;
				end
				2: begin
					if ($urandom_range(0, 1)) begin
						send_trans(8'($urandom_range(5, 255)), 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end else begin
						send_accept(8'($urandom_range(5, 255)), $urandom);
					end
				end
				3, 4, 5: begin
					len = $urandom_range(1, 5);
					for (int i = 0; i < len; i++) begin
						send_byte(letters[$urandom_range(0, 2)]);
					end
					k += len;
				end
				6, 7: begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++) begin
						send_byte($urandom_range(0, 1) ? "1" : "0");
					end
					k += len;
				end
				default: begin
					send_byte($urandom_range(0, 2) == 0 ? NEWLINE : " ");
					k++;
				end
			endcase
		end
	endtask

	// Lets the queued words go in, every token come out, then the block settle.
	task automatic drain();
		wait (word_q.size() == 0 && !tok_in.valid);
		wait (token_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_delim_enable(input bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lex_delim_en = v;
	endtask

	// Input driver: a word stays on the channel until it is taken.
	always @(posedge clk or negedge arst_n) begin
		bit next_valid;
		if (!arst_n) begin
			tok_in.valid <= 1'b0;
		end else if (!tok_in.valid || tok_in.ready) begin
			next_valid = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (word_q.size() != 0) begin
				if (stalls_on && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 18) - 1;
				end else begin
					next_valid = 1'b1;
					tok_in.payload <= word_q.pop_front();
				end
			end
			tok_in.valid <= next_valid;
		end
	end

	// Result sink with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			tok_out.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			snk_gap = $urandom_range(1, 18) - 1;
			tok_out.ready <= 1'b0;
		end else begin
			tok_out.ready <= 1'b1;
		end
	end

	// Monitor: predicts on every accepted input word, then checks any result
	// word taken at the same edge. A result can never belong to a word taken
	// at that very edge, so the order between the two is safe.
	always @(posedge clk) begin
		out_word_t want;
		out_word_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (tok_in.valid && tok_in.ready) begin
				predict_tokens(tok_in.payload);
				moved = 1'b1;
			end
			if (tok_out.valid && tok_out.ready) begin
				moved = 1'b1;
				got = tok_out.payload;
				if (token_q.size() == 0) begin
					report_mismatch("unexpected token first_pos", got.first_pos, 32'd0);
				end else begin
					want = token_q.pop_front();
					if (got.token_kind != want.token_kind)
						report_mismatch("token_kind", 32'(got.token_kind),
							32'(want.token_kind));
					if (got.first_pos != want.first_pos)
						report_mismatch("first_pos", got.first_pos, want.first_pos);
					if (got.end_pos != want.end_pos)
						report_mismatch("end_pos", got.end_pos, want.end_pos);
					if (got.line_number != want.line_number)
						report_mismatch("line_number", got.line_number, want.line_number);
					if (got.type_mask != want.type_mask)
						report_mismatch("type_mask", got.type_mask, want.type_mask);
					if (got.last_of_run != want.last_of_run)
						report_mismatch("last_of_run", 32'(got.last_of_run),
							32'(want.last_of_run));
				end
			end
			// The clearing pass after reset counts against this limit too.
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("dfa_maximal_munch_tokenizer_top test failed");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		tok_in.valid = 1'b0;
		tok_in.payload = '0;
		tok_out.ready = 1'b0;
		error_count = 0;
		src_gap = 0;
		snk_gap = 0;
		quiet_cycles = 0;
		stalls_on = 1'b1;
		lex_delim_en = 1'b0;
		lex_state = 8'd0;
		lex_scan_pos = 0;
		lex_tok_start = 0;
		lex_cand_end = 0;
		lex_prev_end = 0;
		lex_lines = 0;
		lex_cand_line = 0;
		lex_prev_line = 0;
		lex_cand_valid = 1'b0;
		lex_cand_types = 0;
		lex_received = 0;
		lex_skipping = 1'b0;
		lex_end_seen = 1'b0;
		lex_end_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_delim_enable(1'b0);

		// A small lexer: identifiers over a..c (first letter a or b), binary numbers led by 0, space, newline.
		send_trans(0, "a", 1, 1);
		send_trans(0, "b", 1, 1);
		send_trans(1, "a", 1, 1);
		send_trans(1, "b", 1, 1);
		send_trans(1, "c", 1, 1);
		send_trans(0, "0", 2, 1);
		send_trans(2, "0", 2, 1);
		send_trans(2, "1", 2, 1);
		send_trans(0, " ", 3, 1);
		send_trans(0, NEWLINE, 4, 1);
		send_accept(1, 32'h1);
		send_accept(2, 32'h2);
		send_accept(3, 32'h4);
		send_accept(4, 32'h8);
		send_delim(" ", 1);
		send_delim(NEWLINE, 1);
		// Field extremes and codes the block must ignore.
		send_trans(255, 255, 255, 1);
		send_trans(255, 255, 0, 0);
		send_accept(255, 32'hFFFF_FFFF);
		send_delim(255, 1);
		send_delim(255, 0);
		word_q.push_back(noise_word(3'd5));
		word_q.push_back(noise_word(3'd6));
		word_q.push_back(noise_word(3'd7));

		// Matches, a dead byte after a token, and a skip over junk.
		send_text("ab 01\nabcx 1 a\n\nx\nc");
		// A token that never ends fills the ring and overflows.
		for (int i = 0; i < 40; i++) begin
			send_byte("a");
		end
		send_text(" 1");
		drain();

		send_random_stream(40);
		drain();

		// Delimiters on: matches need a following space or newline.
		write_delim_enable(1'b1);
		send_text("ab0 \n\nb1\n");
		send_random_stream(40);
		drain();

		// Last phase runs without stalls and closes the stream.
		write_delim_enable(1'b0);
		stalls_on = 1'b0;
		send_random_stream(24);
		word_q.push_back(noise_word(FUNC_END));
		send_text("ab ");
		word_q.push_back(noise_word(FUNC_END));
		send_accept(7, 32'h10);
		drain();
		write_delim_enable(1'b1);
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("dfa_maximal_munch_tokenizer_top test passed");
		end else begin
			$display("dfa_maximal_munch_tokenizer_top test failed");
		end
		$finish;
	end

endmodule

@@ dfa_maximal_munch_tokenizer_top.f @@
hdl/dmt_pkg.sv
hdl/dmt_ifs.sv
hdl/dmt_ram.sv
hdl/dmt_tables.sv
hdl/dmt_emit.sv
hdl/dmt_engine.sv
hdl/dfa_maximal_munch_tokenizer_top.sv
hdl/dmt_checker.sv
bench/tb_top.sv
